// ===== rtl/tlvc_pkg.sv =====
// Shared types and constants for the TLV deframer with byte cipher.
// No dependencies; every module of the block imports this package.
package tlvc_pkg;

  // Number of big-endian bytes in each length field.
  localparam int LENGTH_BYTES = 4;
  localparam int HDR_CNT_W    = 3;
  localparam int LEN_W        = 32;

  localparam logic [7:0] FRAME_OPCODE   = 8'd2;
  localparam logic [7:0] SESS_ENCRYPT   = 8'd0;
  localparam logic [7:0] SESS_DECRYPT   = 8'd1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [7:0] {
    PH_SESSION_OP = 8'b0000_0001,
    PH_HEADER_LEN = 8'b0000_0010,
    PH_KEY        = 8'b0000_0100,
    PH_FRAME_OP   = 8'b0000_1000,
    PH_FRAME_LEN  = 8'b0001_0000,
    PH_PAYLOAD    = 8'b0010_0000,
    PH_END        = 8'b0100_0000,
    PH_ERROR      = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
  } result_t;

endpackage

// ===== rtl/tlvc_parser.sv =====
// Session and frame parser with the byte cipher for the TLV deframer.
// Depends on tlvc_pkg; updates its state on every accepted input word.
module tlvc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [7:0]        in_byte,
  output tlvc_pkg::result_t res
);
  import tlvc_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [LEN_W-1:0]     rem_len_r, rem_len_nxt;
  logic [7:0]           key_r, key_nxt;
  logic                 decrypt_r, decrypt_nxt;

  logic [HDR_CNT_W:0]   cnt_inc;
  logic                 cnt_last;
  logic [LEN_W-1:0]     len_shift;
  logic [7:0]           cipher_byte;

  assign cnt_inc   = {1'b0, hdr_cnt_r} + {{HDR_CNT_W{1'b0}}, 1'b1};
  assign cnt_last  = (cnt_inc >= (HDR_CNT_W+1)'(LENGTH_BYTES));
  assign len_shift = {rem_len_r[LEN_W-9:0], in_byte};
  assign cipher_byte = decrypt_r ? (in_byte - key_r) : (in_byte + key_r);

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    rem_len_nxt = rem_len_r;
    key_nxt     = key_r;
    decrypt_nxt = decrypt_r;
    res.valid   = 1'b0;
    res.kind    = KIND_DATA;
    res.data    = 8'd0;
    unique case (phase_r)
      PH_SESSION_OP: begin
        if (in_byte == SESS_ENCRYPT || in_byte == SESS_DECRYPT) begin
          decrypt_nxt = in_byte[0];
          hdr_cnt_nxt = '0;
          phase_nxt   = PH_HEADER_LEN;
        end else begin
          phase_nxt = PH_ERROR;
          res.valid = 1'b1;
          res.kind  = KIND_ERROR;
        end
      end
      PH_HEADER_LEN: begin
        hdr_cnt_nxt = cnt_last ? '0 : cnt_inc[HDR_CNT_W-1:0];
        if (cnt_last) begin
          phase_nxt = PH_KEY;
        end
      end
      PH_KEY: begin
        key_nxt   = in_byte;
        phase_nxt = PH_FRAME_OP;
      end
      PH_FRAME_OP: begin
        if (in_byte != FRAME_OPCODE) begin
          phase_nxt = PH_ERROR;
          res.valid = 1'b1;
          res.kind  = KIND_ERROR;
        end else begin
          rem_len_nxt = '0;
          hdr_cnt_nxt = '0;
          phase_nxt   = PH_FRAME_LEN;
        end
      end
      PH_FRAME_LEN: begin
        rem_len_nxt = len_shift;
        hdr_cnt_nxt = cnt_last ? '0 : cnt_inc[HDR_CNT_W-1:0];
        if (cnt_last) begin
          if (len_shift == '0) begin
            phase_nxt = PH_END;
            res.valid = 1'b1;
            res.kind  = KIND_END;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        rem_len_nxt = rem_len_r - LEN_W'(1);
        res.valid   = 1'b1;
        res.kind    = KIND_DATA;
        res.data    = cipher_byte;
        if (rem_len_r == LEN_W'(1)) begin
          phase_nxt = PH_FRAME_OP;
        end
      end
      default: begin
        // End and error phases hold until reset.
        phase_nxt = phase_r;
      end
    endcase
    res.valid = res.valid & in_accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SESSION_OP;
      hdr_cnt_r <= '0;
      rem_len_r <= '0;
      key_r     <= '0;
      decrypt_r <= 1'b0;
    end else if (in_accept) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      rem_len_r <= rem_len_nxt;
      key_r     <= key_nxt;
      decrypt_r <= decrypt_nxt;
    end
  end

endmodule

// ===== rtl/tlvc_outreg.sv =====
// Result register of the TLV deframer: holds one result word for the output stream.
// Depends on tlvc_pkg; tells the input side when a new word may be taken.
module tlvc_outreg (
  input  logic              clk,
  input  logic              rst_n,
  input  tlvc_pkg::result_t res,
  output logic              load_ok,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [1:0]        out_tuser,
  output logic [7:0]        out_tdata
);
  import tlvc_pkg::*;

  logic       valid_r;
  kind_t      kind_r;
  logic [7:0] data_r;

  // The register can take a new word whenever it is empty or being drained.
  assign load_ok = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ok) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && res.valid) begin
      kind_r <= res.kind;
      data_r <= res.data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = data_r;

endmodule

// ===== rtl/tlv_deframer_caesar_cipher.sv =====
// TLV deframer with byte cipher: one input word per cycle unless the output register stalls.
// A result is registered and drives out_tvalid in the cycle after its input word is accepted;
// input is stalled only while the single output register is full and out_tready is low.
// Synchronous active-low reset returns the parser to the session opcode and empties the output.
// Depends on tlvc_pkg, tlvc_parser and tlvc_outreg.
module tlv_deframer_caesar_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [1:0] out_tuser,   // [1:0] kind
  output logic [7:0] out_tdata    // [7:0] out_byte
);
  import tlvc_pkg::*;

  result_t res;
  logic    load_ok;
  logic    in_accept;

  assign in_tready = load_ok;
  assign in_accept = in_tvalid && load_ok;

  tlvc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .res       (res)
  );

  tlvc_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
